// ===== design/tdt_pkg.sv =====
`timescale 1ns / 1ps

package tdt_pkg;

    // Slot count of the automaton (symbol slots, states, transitions) and field widths
    localparam int SLOTS      = 10;
    localparam int IDX_W      = 4;
    localparam int TR_W       = 12;
    localparam int TR_PER_REG = 5;
    localparam int TR_ALL_W   = 2 * TR_PER_REG * TR_W;
    localparam int FLAG_W     = 3;

    localparam logic [IDX_W-1:0] NO_STATE  = 4'hF;
    localparam logic [IDX_W-1:0] SLOT_LIM  = 4'(SLOTS);

    // Bits inside one state's flag group
    localparam int FLG_INITIAL = 0;
    localparam int FLG_ACCEPT  = 1;
    localparam int FLG_DISCARD = 2;

    // Bytes that the classes test
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_QUEST = 8'h3F;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LO_P  = 8'h70;
    localparam logic [7:0] CH_LO_S  = 8'h73;
    localparam logic [7:0] CH_LO_W  = 8'h77;
    localparam logic [7:0] CH_UP_P  = 8'h50;
    localparam logic [7:0] CH_UP_S  = 8'h53;
    localparam logic [7:0] CH_UP_W  = 8'h57;

    typedef enum logic [3:0] {
        CLS_NOT_SPACE,
        CLS_SENTENCE,
        CLS_TERM,
        CLS_DOT,
        CLS_SPACE,
        CLS_NOT_NL,
        CLS_QUERY,
        CLS_DIGIT,
        CLS_JUNK
    } t_class;

    typedef enum logic [2:0] {
        REG_SYM_CLASSES,
        REG_SYM_COUNT,
        REG_STATE_FLAGS,
        REG_STATE_COUNT,
        REG_TR_FIRST,
        REG_TR_SECOND,
        REG_TR_COUNT
    } t_reg_idx;

    // Symbol lookup result
    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] idx;
    } t_sym;

    // Transition step result
    typedef struct packed {
        logic             halted;
        logic             kept;
        logic             commit;
        logic [IDX_W-1:0] next;
    } t_step;

    function automatic logic [IDX_W-1:0] lim_count(input logic [IDX_W-1:0] cnt);
        return (cnt > SLOT_LIM) ? SLOT_LIM : cnt;
    endfunction

    function automatic logic is_query(input logic [7:0] c);
        return (c == CH_LO_P) || (c == CH_LO_S) || (c == CH_LO_W) ||
               (c == CH_UP_P) || (c == CH_UP_S) || (c == CH_UP_W);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic class_match(input logic [3:0] code, input logic [7:0] c);
        logic m;
        case (t_class'(code))
            CLS_NOT_SPACE: m = (c != CH_SPACE);
            CLS_SENTENCE:  m = (c != CH_SPACE) && (c != CH_DOT) &&
                               (c != CH_BANG) && (c != CH_QUEST);
            CLS_TERM:      m = (c == CH_BANG) || (c == CH_QUEST);
            CLS_DOT:       m = (c == CH_DOT);
            CLS_SPACE:     m = (c == CH_SPACE);
            CLS_NOT_NL:    m = (c != CH_LF) && (c != CH_CR);
            CLS_QUERY:     m = is_query(c);
            CLS_DIGIT:     m = is_digit(c);
            CLS_JUNK:      m = !is_query(c) && !is_digit(c);
            default:       m = 1'b0;
        endcase
        return m;
    endfunction

endpackage

// ===== design/tdt_in_if.sv =====
`timescale 1ns / 1ps

interface tdt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       new_run;

    modport source (output valid, output in_char, output new_run, input ready);
    modport sink   (input valid, input in_char, input new_run, output ready);
endinterface

// ===== design/tdt_out_if.sv =====
`timescale 1ns / 1ps

interface tdt_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       kept;
    logic       commit;
    logic       halted;
    logic [3:0] state_now;

    modport source (output valid, output out_char, output kept, output commit,
                    output halted, output state_now, input ready);
    modport sink   (input valid, input out_char, input kept, input commit,
                    input halted, input state_now, output ready);
endinterface

// ===== design/table_driven_dfa_tokenizer_top.sv =====
`timescale 1ns / 1ps

// Programmable character-class tokenizer: one text byte per beat on i_in,
// one result beat per byte on o_out, in order. A byte is classified, stepped
// through the transition table and registered into the output stage in the
// cycle it is accepted, so the block takes one byte every clock as long as
// o_out is drained; the output register is the only stage, and the byte-to-byte
// path runs through the current-state register (class compare, first-match
// priority over ten transitions, flag lookup). A result appears in the cycle after
// its byte is accepted. Configuration is written over the APB port at byte
// address 8*index with 64-bit data; write it only while no byte is in flight.
module table_driven_dfa_tokenizer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tdt_in_if.sink      i_in,
    tdt_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import tdt_pkg::*;

    // Configuration registers
    logic [4*SLOTS-1:0]           r_sym_classes;
    logic [IDX_W-1:0]             r_sym_count;
    logic [FLAG_W*SLOTS-1:0]      r_state_flags;
    logic [IDX_W-1:0]             r_state_count;
    logic [TR_ALL_W/2-1:0]        r_tr_first;
    logic [TR_ALL_W/2-1:0]        r_tr_second;
    logic [IDX_W-1:0]             r_tr_count;

    // Run state and output stage
    logic [IDX_W-1:0] r_cur;
    logic             r_at_start;
    logic             r_valid;
    logic [7:0]       r_char;
    t_step            r_step;

    logic             w_cfg_wr;
    t_reg_idx         w_reg;
    logic [IDX_W-1:0] w_nsym;
    logic [IDX_W-1:0] w_nst;
    logic [IDX_W-1:0] w_ntr;
    logic [IDX_W-1:0] w_first_init;
    logic [IDX_W-1:0] w_cur;
    logic             w_acc;
    t_sym             w_sym;
    t_step            w_step;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;
    assign w_reg    = t_reg_idx'(paddr[5:3]);

    // Write configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sym_classes <= '0;
            r_sym_count   <= '0;
            r_state_flags <= '0;
            r_state_count <= '0;
            r_tr_first    <= '0;
            r_tr_second   <= '0;
            r_tr_count    <= '0;
        end else if (w_cfg_wr) begin
            case (w_reg)
                REG_SYM_CLASSES: r_sym_classes <= pwdata[4*SLOTS-1:0];
                REG_SYM_COUNT:   r_sym_count   <= pwdata[IDX_W-1:0];
                REG_STATE_FLAGS: r_state_flags <= pwdata[FLAG_W*SLOTS-1:0];
                REG_STATE_COUNT: r_state_count <= pwdata[IDX_W-1:0];
                REG_TR_FIRST:    r_tr_first    <= pwdata[TR_ALL_W/2-1:0];
                REG_TR_SECOND:   r_tr_second   <= pwdata[TR_ALL_W/2-1:0];
                REG_TR_COUNT:    r_tr_count    <= pwdata[IDX_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back configuration
    always_comb begin
        case (w_reg)
            REG_SYM_CLASSES: prdata = 64'(r_sym_classes);
            REG_SYM_COUNT:   prdata = 64'(r_sym_count);
            REG_STATE_FLAGS: prdata = 64'(r_state_flags);
            REG_STATE_COUNT: prdata = 64'(r_state_count);
            REG_TR_FIRST:    prdata = 64'(r_tr_first);
            REG_TR_SECOND:   prdata = 64'(r_tr_second);
            REG_TR_COUNT:    prdata = 64'(r_tr_count);
            default:         prdata = '0;
        endcase
    end

    assign w_nsym = lim_count(r_sym_count);
    assign w_nst  = lim_count(r_state_count);
    assign w_ntr  = lim_count(r_tr_count);

    // Find the first initial state in use
    always_comb begin
        w_first_init = NO_STATE;
        for (int s = SLOTS - 1; s >= 0; s--) begin
            if ((IDX_W'(s) < w_nst) && r_state_flags[FLAG_W*s + FLG_INITIAL]) begin
                w_first_init = IDX_W'(s);
            end
        end
    end

    // Restart the run when asked, after reset or after a halt
    assign w_cur = (i_in.new_run || r_at_start) ? w_first_init : r_cur;

    tdt_classify u_classify (
        .i_char    (i_in.in_char),
        .i_classes (r_sym_classes),
        .i_nsym    (w_nsym),
        .o_sym     (w_sym)
    );

    tdt_trans u_trans (
        .i_cur    (w_cur),
        .i_sym    (w_sym),
        .i_nst    (w_nst),
        .i_ntr    (w_ntr),
        .i_tr_all ({r_tr_second, r_tr_first}),
        .i_flags  (r_state_flags),
        .o_step   (w_step)
    );

    assign i_in.ready = !r_valid || o_out.ready;
    assign w_acc      = i_in.valid && i_in.ready;

    // Advance run state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_cur      <= NO_STATE;
            r_at_start <= 1'b1;
        end else if (w_acc) begin
            r_valid    <= 1'b1;
            r_cur      <= w_step.next;
            r_at_start <= w_step.halted;
        end else if (o_out.ready) begin
            r_valid    <= 1'b0;
        end
    end

    // Load the result beat
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_char <= i_in.in_char;
            r_step <= w_step;
        end
    end

    assign o_out.valid     = r_valid;
    assign o_out.out_char  = r_char;
    assign o_out.kept      = r_step.kept;
    assign o_out.commit    = r_step.commit;
    assign o_out.halted    = r_step.halted;
    assign o_out.state_now = r_step.next;

endmodule

// ===== design/tdt_classify.sv =====
`timescale 1ns / 1ps

module tdt_classify (
    input  logic [7:0]                         i_char,
    input  logic [4*tdt_pkg::SLOTS-1:0]        i_classes,
    input  logic [tdt_pkg::IDX_W-1:0]          i_nsym,
    output tdt_pkg::t_sym                      o_sym
);
    import tdt_pkg::*;

    logic [SLOTS-1:0] w_match;

    // Test every slot in use against the byte
    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            w_match[i] = (IDX_W'(i) < i_nsym) && class_match(i_classes[4*i +: 4], i_char);
        end
    end

    // Pick the lowest matching slot
    always_comb begin
        o_sym.hit = 1'b0;
        o_sym.idx = NO_STATE;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (w_match[i]) begin
                o_sym.hit = 1'b1;
                o_sym.idx = IDX_W'(i);
            end
        end
    end

endmodule

// ===== design/tdt_trans.sv =====
`timescale 1ns / 1ps

module tdt_trans (
    input  logic [tdt_pkg::IDX_W-1:0]             i_cur,
    input  tdt_pkg::t_sym                         i_sym,
    input  logic [tdt_pkg::IDX_W-1:0]             i_nst,
    input  logic [tdt_pkg::IDX_W-1:0]             i_ntr,
    input  logic [tdt_pkg::TR_ALL_W-1:0]          i_tr_all,
    input  logic [tdt_pkg::FLAG_W*tdt_pkg::SLOTS-1:0] i_flags,
    output tdt_pkg::t_step                        o_step
);
    import tdt_pkg::*;

    logic [SLOTS-1:0]  w_hit;
    logic              w_found;
    logic [IDX_W-1:0]  w_next;
    logic [FLAG_W-1:0] w_nflags;
    logic              w_live;

    assign w_live = i_sym.hit && (i_cur < i_nst);

    // Compare every transition in use in parallel
    always_comb begin
        for (int t = 0; t < SLOTS; t++) begin
            w_hit[t] = w_live && (IDX_W'(t) < i_ntr) &&
                       (i_tr_all[TR_W*t +: IDX_W] == i_cur) &&
                       (i_tr_all[TR_W*t + IDX_W +: IDX_W] == i_sym.idx) &&
                       (i_tr_all[TR_W*t + 2*IDX_W +: IDX_W] < i_nst);
        end
    end

    // Take the first transition that hits
    always_comb begin
        w_found = 1'b0;
        w_next  = NO_STATE;
        for (int t = SLOTS - 1; t >= 0; t--) begin
            if (w_hit[t]) begin
                w_found = 1'b1;
                w_next  = i_tr_all[TR_W*t + 2*IDX_W +: IDX_W];
            end
        end
    end

    // Look up the destination's flags
    always_comb begin
        w_nflags = '0;
        for (int s = 0; s < SLOTS; s++) begin
            if (w_next == IDX_W'(s)) begin
                w_nflags = i_flags[FLAG_W*s +: FLAG_W];
            end
        end
    end

    assign o_step.halted = !w_found;
    assign o_step.kept   = w_found && !w_nflags[FLG_DISCARD];
    assign o_step.commit = w_found && w_nflags[FLG_ACCEPT];
    assign o_step.next   = w_found ? w_next : NO_STATE;

endmodule

// ===== design/tdt_checker.sv =====
`timescale 1ns / 1ps

module tdt_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic [7:0] i_in_char,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_char,
    input logic       i_out_kept,
    input logic       i_out_commit,
    input logic       i_out_halted,
    input logic [3:0] i_out_state
);
    import tdt_pkg::*;

    // Reset empties the output stage
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // A stalled result beat holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_char) &&
            $stable(i_out_state) && $stable(i_out_halted))
        else $error("stalled result changed");

    // An accepted byte is echoed in the next cycle
    a_echo: assert property (@(posedge i_clk)
        i_rst_n && i_in_valid && i_in_ready |=> i_out_valid &&
            (i_out_char == $past(i_in_char)))
        else $error("accepted byte not echoed");

    // A halted byte carries no state and no flags
    a_halt_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_halted |-> (i_out_state == NO_STATE) &&
            !i_out_kept && !i_out_commit)
        else $error("halted result not clean");

    // A step that did not halt names a real state
    a_live_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_halted |-> (i_out_state != NO_STATE))
        else $error("live result without state");

endmodule

bind table_driven_dfa_tokenizer_top tdt_checker u_tdt_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_in_char    (i_in.in_char),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_char   (o_out.out_char),
    .i_out_kept   (o_out.kept),
    .i_out_commit (o_out.commit),
    .i_out_halted (o_out.halted),
    .i_out_state  (o_out.state_now)
);

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import tdt_pkg::*;

    localparam int TXT_PROSE = 0;
    localparam int TXT_QUERY = 1;
    localparam int TXT_MIXED = 2;

    localparam int RX_OPEN   = 0;
    localparam int RX_RANDOM = 1;
    localparam int RX_CHOKE  = 2;

    // One result beat as the block reports it
    typedef struct packed {
        logic [7:0] ch;
        logic       kept;
        logic       commit;
        logic       halted;
        logic [3:0] st;
    } t_beat;

    // Register image of one automaton setup
    typedef struct packed {
        logic [39:0] codes;
        logic [3:0]  nsym;
        logic [29:0] flags;
        logic [3:0]  nst;
        logic [59:0] tr_a;
        logic [59:0] tr_b;
        logic [3:0]  ntr;
    } t_dfa_cfg;

    // Track the automaton and the result beats still owed by the block
    class t_scoreboard;
        logic [39:0] sym_codes;
        logic [3:0]  sym_cnt;
        logic [29:0] st_flags;
        logic [3:0]  st_cnt;
        logic [59:0] tr_lo;
        logic [59:0] tr_hi;
        logic [3:0]  tr_cnt;
        logic [3:0]  cur_state;
        bit          run_start;
        t_beat       expected_steps[$];
        int          mismatches;

        function new();
            sym_codes = '0;
            sym_cnt   = '0;
            st_flags  = '0;
            st_cnt    = '0;
            tr_lo     = '0;
            tr_hi     = '0;
            tr_cnt    = '0;
            cur_state = NO_STATE;
            run_start = 1'b1;
            mismatches = 0;
        endfunction

        function void write_reg(t_reg_idx idx, logic [63:0] v);
            case (idx)
                REG_SYM_CLASSES: sym_codes = v[39:0];
                REG_SYM_COUNT:   sym_cnt   = v[3:0];
                REG_STATE_FLAGS: st_flags  = v[29:0];
                REG_STATE_COUNT: st_cnt    = v[3:0];
                REG_TR_FIRST:    tr_lo     = v[59:0];
                REG_TR_SECOND:   tr_hi     = v[59:0];
                REG_TR_COUNT:    tr_cnt    = v[3:0];
                default: ;
            endcase
        endfunction

        // Clamp a count to the slots that the registers hold
        function int capped(logic [3:0] n);
            return (n > SLOT_LIM) ? SLOTS : int'(n);
        endfunction

        function bit byte_in_class(logic [3:0] code, logic [7:0] c);
            bit query;
            bit digit;
            query = (c == CH_LO_P) || (c == CH_LO_S) || (c == CH_LO_W) ||
                    (c == CH_UP_P) || (c == CH_UP_S) || (c == CH_UP_W);
            digit = (c >= CH_ZERO) && (c <= CH_NINE);
            case (code)
                CLS_NOT_SPACE: return c != CH_SPACE;
                CLS_SENTENCE:  return (c != CH_SPACE) && (c != CH_DOT) &&
                                      (c != CH_BANG) && (c != CH_QUEST);
                CLS_TERM:      return (c == CH_BANG) || (c == CH_QUEST);
                CLS_DOT:       return c == CH_DOT;
                CLS_SPACE:     return c == CH_SPACE;
                CLS_NOT_NL:    return (c != CH_LF) && (c != CH_CR);
                CLS_QUERY:     return query;
                CLS_DIGIT:     return digit;
                CLS_JUNK:      return !query && !digit;
                default:       return 1'b0;
            endcase
        endfunction

        // Predict the result of one accepted byte and queue it
        function void note_byte(logic [7:0] c, logic nr);
            t_beat       r;
            logic [3:0]  sym;
            logic [3:0]  nxt;
            logic [11:0] w;
            int          nst;
            nst = capped(st_cnt);
            if (nr || run_start) begin
                cur_state = NO_STATE;
                for (int i = nst - 1; i >= 0; i--) begin
                    if (st_flags[3*i + FLG_INITIAL]) cur_state = 4'(i);
                end
            end
            run_start = 1'b0;

            // First symbol slot whose class takes the byte
            sym = NO_STATE;
            for (int i = 0; i < capped(sym_cnt); i++) begin
                if (sym == NO_STATE && byte_in_class(sym_codes[4*i +: 4], c)) sym = 4'(i);
            end

            // First transition out of the current state on that symbol
            nxt = NO_STATE;
            if (sym != NO_STATE && cur_state < nst) begin
                for (int i = 0; i < capped(tr_cnt); i++) begin
                    w = (i < TR_PER_REG) ? tr_lo[TR_W*i +: TR_W]
                                         : tr_hi[TR_W*(i - TR_PER_REG) +: TR_W];
                    if (nxt == NO_STATE && w[3:0] == cur_state && w[7:4] == sym &&
                        w[11:8] < nst) begin
                        nxt = w[11:8];
                    end
                end
            end

            r.ch = c;
            if (nxt == NO_STATE) begin
                r.kept    = 1'b0;
                r.commit  = 1'b0;
                r.halted  = 1'b1;
                r.st      = NO_STATE;
                cur_state = NO_STATE;
                run_start = 1'b1;
            end else begin
                r.kept    = ~st_flags[3*nxt + FLG_DISCARD];
                r.commit  = st_flags[3*nxt + FLG_ACCEPT];
                r.halted  = 1'b0;
                r.st      = nxt;
                cur_state = nxt;
            end
            expected_steps.push_back(r);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected %0h, actual %0h", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_step(t_beat got);
            t_beat want;
            if (expected_steps.size() == 0) begin
                $error("result beat with none pending: out_char %0h", got.ch);
                mismatches++;
                return;
            end
            want = expected_steps.pop_front();
            compare_field("out_char", want.ch, got.ch);
            compare_field("kept", want.kept, got.kept);
            compare_field("commit", want.commit, got.commit);
            compare_field("halted", want.halted, got.halted);
            compare_field("state_now", want.st, got.st);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    tdt_in_if  in_bus ();
    tdt_out_if out_bus ();

    table_driven_dfa_tokenizer_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    t_scoreboard tracker = new();
    bit src_valid  = 1'b0;
    int burst_left = 1;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs
    initial begin
        #3_000_000;
        $display("table_driven_dfa_tokenizer_top: mismatch");
        $finish;
    end

    // Stall the result side in stretches: open, random, mostly blocked
    initial begin
        int span;
        int mode;
        out_bus.ready <= 1'b0;
        forever begin
            span = $urandom_range(8, 60);
            mode = $urandom_range(RX_OPEN, RX_CHOKE);
            repeat (span) begin
                @(posedge i_clk);
                case (mode)
                    RX_OPEN:   out_bus.ready <= 1'b1;
                    RX_RANDOM: out_bus.ready <= 1'($urandom_range(0, 1));
                    default:   out_bus.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Check every result beat the block hands over
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
            tracker.check_step({out_bus.out_char, out_bus.kept, out_bus.commit,
                                out_bus.halted, out_bus.state_now});
        end
    end

    function automatic logic [11:0] trans(logic [3:0] src_st, logic [3:0] sym,
                                          logic [3:0] dst_st);
        return {dst_st, sym, src_st};
    endfunction

    // Sentence splitter: words, spaces kept inside, ends on dot or terminator
    function automatic t_dfa_cfg sentence_cfg();
        t_dfa_cfg c;
        c = '0;
        c.codes[0 +: 4]  = CLS_TERM;
        c.codes[4 +: 4]  = CLS_DOT;
        c.codes[8 +: 4]  = CLS_SPACE;
        c.codes[12 +: 4] = CLS_NOT_NL;
        c.codes[16 +: 4] = CLS_DIGIT;
        c.nsym = 4'd5;
        c.flags[FLG_INITIAL]     = 1'b1;
        c.flags[FLG_DISCARD]     = 1'b1;
        c.flags[6 + FLG_ACCEPT]  = 1'b1;
        c.flags[9 + FLG_DISCARD] = 1'b1;
        c.nst = 4'd4;
        // slots: 0 terminator, 1 dot, 2 space, 3 other text
        c.tr_a = {trans(1, 0, 2), trans(1, 2, 1), trans(1, 3, 1), trans(0, 2, 0),
                  trans(0, 3, 1)};
        c.tr_b = {trans(2, 3, 1), trans(3, 3, 1), trans(3, 2, 3), trans(2, 2, 3),
                  trans(1, 1, 2)};
        c.ntr = 4'd10;
        return c;
    endfunction

    // Query-name tokens followed by digits; first entry points at an out-of-range state
    function automatic t_dfa_cfg query_cfg();
        t_dfa_cfg c;
        c = '0;
        c.codes[0 +: 4] = CLS_QUERY;
        c.codes[4 +: 4] = CLS_DIGIT;
        c.codes[8 +: 4] = CLS_JUNK;
        c.nsym = 4'd3;
        c.flags[FLG_INITIAL]     = 1'b1;
        c.flags[FLG_DISCARD]     = 1'b1;
        c.flags[6 + FLG_ACCEPT]  = 1'b1;
        c.flags[9 +: 3]          = 3'b111;
        c.nst = 4'd4;
        c.tr_a = {trans(2, 1, 2), trans(1, 1, 2), trans(1, 0, 1), trans(0, 0, 1),
                  trans(0, 0, 9)};
        c.tr_b = {12'hFFF, trans(0, 2, 0), trans(1, 2, 0), trans(2, 2, 0),
                  trans(2, 0, 1)};
        c.ntr = 4'd9;
        return c;
    endfunction

    // Mostly well-formed tables with some out-of-range fields mixed in
    function automatic t_dfa_cfg random_cfg();
        t_dfa_cfg    c;
        logic [11:0] w;
        int          nst;
        int          nsym;
        c.nsym = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(11, 15))
                                             : 4'($urandom_range(1, 10));
        c.nst  = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(11, 15))
                                             : 4'($urandom_range(2, 10));
        c.ntr  = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(11, 15))
                                             : 4'($urandom_range(1, 10));
        nsym = (c.nsym > SLOT_LIM) ? SLOTS : int'(c.nsym);
        nst  = (c.nst > SLOT_LIM) ? SLOTS : int'(c.nst);
        for (int i = 0; i < SLOTS; i++) begin
            c.codes[4*i +: 4] = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(9, 15))
                                                            : 4'($urandom_range(0, 8));
        end
        c.flags = 30'($urandom);
        for (int t = 0; t < 2 * TR_PER_REG; t++) begin
            if ($urandom_range(0, 5) == 0) begin
                w = 12'($urandom);
            end else begin
                w = trans(4'($urandom_range(0, nst - 1)), 4'($urandom_range(0, nsym - 1)),
                          4'($urandom_range(0, nst - 1)));
            end
            if (t < TR_PER_REG) begin
                c.tr_a[TR_W*t +: TR_W] = w;
            end else begin
                c.tr_b[TR_W*(t - TR_PER_REG) +: TR_W] = w;
            end
        end
        return c;
    endfunction

    function automatic logic [7:0] text_byte(int flavor);
        logic [7:0] names[6] = '{CH_LO_P, CH_LO_S, CH_LO_W, CH_UP_P, CH_UP_S, CH_UP_W};
        int         r;
        r = $urandom_range(0, 99);
        case (flavor)
            TXT_PROSE: begin
                if (r < 50) return 8'($urandom_range(8'h61, 8'h7A));
                if (r < 68) return CH_SPACE;
                if (r < 74) return CH_DOT;
                if (r < 78) return ($urandom_range(0, 1) != 0) ? CH_BANG : CH_QUEST;
                if (r < 81) return ($urandom_range(0, 1) != 0) ? CH_LF : CH_CR;
                return 8'($urandom_range(0, 255));
            end
            TXT_QUERY: begin
                if (r < 35) return names[$urandom_range(0, 5)];
                if (r < 60) return 8'($urandom_range(CH_ZERO, CH_NINE));
                if (r < 75) return CH_SPACE;
                return 8'($urandom_range(0, 255));
            end
            default: begin
                if (r < 50) return 8'($urandom_range(0, 255));
                return text_byte($urandom_range(TXT_PROSE, TXT_QUERY));
            end
        endcase
    endfunction

    // Offer one byte, hold it until taken, then maybe pause between bursts
    task automatic push_byte(input logic [7:0] c, input logic nr);
        in_bus.valid   <= 1'b1;
        in_bus.in_char <= c;
        in_bus.new_run <= nr;
        src_valid = 1'b1;
        do @(posedge i_clk); while (in_bus.ready !== 1'b1);
        tracker.note_byte(c, nr);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            in_bus.valid <= 1'b0;
            src_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic drop_source();
        if (src_valid) begin
            in_bus.valid <= 1'b0;
            src_valid = 1'b0;
        end
    endtask

    // Drain the block, then write every register over APB
    task automatic load_config(input t_dfa_cfg cfg);
        logic [63:0] vals[REG_TR_COUNT + 1];
        drop_source();
        while (tracker.expected_steps.size() != 0) @(posedge i_clk);
        vals[REG_SYM_CLASSES] = 64'(cfg.codes);
        vals[REG_SYM_COUNT]   = 64'(cfg.nsym);
        vals[REG_STATE_FLAGS] = 64'(cfg.flags);
        vals[REG_STATE_COUNT] = 64'(cfg.nst);
        vals[REG_TR_FIRST]    = 64'(cfg.tr_a);
        vals[REG_TR_SECOND]   = 64'(cfg.tr_b);
        vals[REG_TR_COUNT]    = 64'(cfg.ntr);
        for (int r = REG_SYM_CLASSES; r <= REG_TR_COUNT; r++) begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= 6'(r * 8);
            pwdata  <= vals[r];
            @(posedge i_clk);
            penable <= 1'b1;
            do @(posedge i_clk); while (pready !== 1'b1);
            tracker.write_reg(t_reg_idx'(r), vals[r]);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial begin
        t_dfa_cfg cfg;
        string    txt;

        i_rst_n        <= 1'b0;
        in_bus.valid   <= 1'b0;
        in_bus.in_char <= 8'h00;
        in_bus.new_run <= 1'b0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset tables: no symbol slots, so every byte halts
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b1);

        // Sentence tables: terminator, dot, space and text bytes, commit, discard, halt and forced restart
        load_config(sentence_cfg());
        txt = "Sp w7.  P!?\n09W\r";
        for (int i = 0; i < txt.len(); i++) push_byte(txt[i], i == 13);

        // Oversized counts, unknown codes, dead transition fields, last slots only
        cfg = '0;
        for (int i = 0; i < SLOTS - 1; i++) cfg.codes[4*i +: 4] = 4'(9 + i % 7);
        cfg.codes[4*(SLOTS-1) +: 4] = CLS_NOT_SPACE;
        cfg.nsym = 4'hF;
        for (int i = 0; i < SLOTS - 1; i++) cfg.flags[3*i + FLG_ACCEPT] = 1'b1;
        cfg.flags[3*(SLOTS-1) +: 3] = 3'b111;
        cfg.nst = 4'hF;
        cfg.tr_a = {trans(3, 9, 4), trans(9, 9, 12), trans(9, 9, NO_STATE),
                    trans(9, 12, 9), trans(NO_STATE, 9, 9)};
        cfg.tr_b = {trans(9, 9, 9), trans(3, 9, 4), trans(3, 9, 4), trans(3, 9, 4),
                    trans(3, 9, 4)};
        cfg.ntr = 4'hF;
        load_config(cfg);
        push_byte(8'h61, 1'b0);
        push_byte(CH_SPACE, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h80, 1'b1);

        // No initial state anywhere: the run cannot start
        cfg = sentence_cfg();
        cfg.flags[FLG_INITIAL] = 1'b0;
        load_config(cfg);
        push_byte(8'h61, 1'b1);
        push_byte(CH_DOT, 1'b0);

        // Every register at its top value
        load_config('1);
        push_byte(8'h7F, 1'b0);
        push_byte(CH_SPACE, 1'b1);

        // Random phases; state carries over each table change
        for (int ph = 0; ph < 12; ph++) begin
            case (ph % 4)
                0: begin
                    load_config(sentence_cfg());
                    repeat (50) push_byte(text_byte(TXT_PROSE), $urandom_range(0, 9) == 0);
                end
                1: begin
                    load_config(query_cfg());
                    repeat (50) push_byte(text_byte(TXT_QUERY), $urandom_range(0, 9) == 0);
                end
                2: begin
                    load_config(random_cfg());
                    repeat (50) push_byte(text_byte(TXT_MIXED), $urandom_range(0, 9) == 0);
                end
                default: begin
                    load_config(random_cfg());
                    repeat (50) push_byte(text_byte(TXT_PROSE), $urandom_range(0, 9) == 0);
                end
            endcase
        end

        // Drain and let any stray beat show up
        drop_source();
        while (tracker.expected_steps.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.expected_steps.size() == 0) begin
            $display("table_driven_dfa_tokenizer_top: match");
        end else begin
            $display("table_driven_dfa_tokenizer_top: mismatch");
        end
        $finish;
    end

endmodule
